/* design/gn23_pkg.sv */
// package: permutation table, widths and register codes for the noise core
`timescale 1ns / 1ps
`default_nettype none
package gn23_pkg;
  localparam int FracBitsDefault = 16;
  localparam int CoordW = 32;
  localparam int FreqW = 24;
  localparam int OutW = 18;
  localparam int AddrW = 3;
  localparam logic [AddrW-1:0] RegMode = 3'd0;
  localparam logic [AddrW-1:0] RegFreq = 3'd4;
  localparam logic [FreqW-1:0] FreqReset = 24'd65536;

  localparam logic [7:0] PermRom [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
    8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
    8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
    8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
    8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
    8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
    8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
    8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,
    8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
    8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,
    8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,
    8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,
    8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] pm(input logic [7:0] i);
    pm = PermRom[i];
  endfunction
endpackage
`default_nettype wire

/* design/gn23_lerp.sv */
// registered lerp stage: y = a + floor(f*(b-a)/one)
`timescale 1ns / 1ps
`default_nettype none
module gn23_lerp import gn23_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault,
  parameter int VW = FRAC_BITS + 4
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [FRAC_BITS:0]   f,
  input  wire logic signed [VW-1:0] a,
  input  wire logic signed [VW-1:0] b,
  output logic signed [VW-1:0]      y
);
  logic signed [VW:0] diff;
  logic signed [VW+FRAC_BITS+1:0] prod;
  assign diff = (VW+1)'(b) - (VW+1)'(a);
  assign prod = $signed({1'b0, f}) * diff;

  always_ff @(posedge clk) begin
    if (en) begin
      y <= a + VW'(prod >>> FRAC_BITS);
    end
  end
endmodule
`default_nettype wire

/* design/gradient_noise_2d_3d_core.sv */
// top level: improved gradient noise, 2d/3d, fully pipelined
//
// in: coord_x/y/z on valid/ready; out: noise_value on valid/ready.
// the pipeline has nine register stages plus the output register:
// scale multiply, wrap/fraction, two hash lookups, fade products,
// gradient dots, three lerp levels and output scaling. one
// transaction per cycle is accepted while the output is taken; the
// whole pipe advances together, so a stall on the output holds every
// stage and in_ready falls only when the last stage holds a result.
// reset clears the valid bits, sets noise_mode to 3d and frequency to
// 1.0. configuration goes through the apb port at 0 (mode) and 4
// (frequency); write it only while the pipe is empty.
`timescale 1ns / 1ps
`default_nettype none
module gradient_noise_2d_3d_core import gn23_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [AddrW-1:0]         paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [CoordW-1:0] coord_x,
  input  wire logic signed [CoordW-1:0] coord_y,
  input  wire logic signed [CoordW-1:0] coord_z,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [OutW-1:0]        noise_value
);
  localparam int FB = FRAC_BITS;
  localparam int VW = FB + 4;
  localparam int NS = 10;

  logic             noise_mode;
  logic [FreqW-1:0] frequency;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_mode <= 1'b1;
      frequency  <= FreqReset;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegMode) noise_mode <= pwdata[0];
      else if (paddr == RegFreq) frequency <= pwdata[FreqW-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == RegMode) prdata = 32'(noise_mode);
    else if (paddr == RegFreq) prdata = 32'(frequency);
  end

  // pipe advance: whole pipe moves unless the output stage is held
  logic [NS-1:0] vld;
  logic          adv;
  assign adv = !vld[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NS-1];
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], in_valid};
  end

  // s1: scale
  logic signed [CoordW+FreqW:0] p1 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      p1[0] <= coord_x * $signed({1'b0, frequency});
      p1[1] <= coord_y * $signed({1'b0, frequency});
      p1[2] <= coord_z * $signed({1'b0, frequency});
    end
  end

  // s2: cell and fraction, z is unused in 2d
  logic [7:0]    ci2 [3];
  logic [FB-1:0] t2  [3];
  logic          m2;
  always_ff @(posedge clk) begin
    if (adv) begin
      m2 <= noise_mode;
      for (int k = 0; k < 3; k++) begin
        ci2[k] <= p1[k][39:32];
        t2[k]  <= p1[k][31 -: FB];
      end
    end
  end

  // s3: first hash level, t squared
  logic [8:0]     a3, b3;
  logic [7:0]     ci3 [3];
  logic [FB-1:0]  t3  [3];
  logic [2*FB-1:0] sq3 [3];
  logic           m3;
  always_ff @(posedge clk) begin
    if (adv) begin
      a3 <= 9'(pm(ci2[0])) + 9'(ci2[1]);
      b3 <= 9'(pm(ci2[0] + 8'd1)) + 9'(ci2[1]);
      m3 <= m2;
      for (int k = 0; k < 3; k++) begin
        ci3[k] <= ci2[k];
        t3[k]  <= t2[k];
        sq3[k] <= t2[k] * t2[k];
      end
    end
  end

  // s4: second hash level, t^3 and quadratic factor q of the quintic fade
  logic [8:0]     aa4, ab4, ba4, bb4;
  logic [FB-1:0]  t4  [3];
  logic [FB+1:0]  tt4 [3];
  logic [FB+3:0]  q4  [3];
  logic           m4;
  always_ff @(posedge clk) begin
    if (adv) begin
      aa4 <= 9'(pm(a3[7:0])) + 9'(ci3[2]);
      ab4 <= 9'(pm(a3[7:0] + 8'd1)) + 9'(ci3[2]);
      ba4 <= 9'(pm(b3[7:0])) + 9'(ci3[2]);
      bb4 <= 9'(pm(b3[7:0] + 8'd1)) + 9'(ci3[2]);
      m4  <= m3;
      for (int k = 0; k < 3; k++) begin
        t4[k]  <= t3[k];
        tt4[k] <= (FB+2)'(((2*FB)'(sq3[k] >> FB) * t3[k]) >> FB);
        q4[k]  <= (FB+4)'(((2*FB+5)'(6) * sq3[k] + ((2*FB+5)'(10) << (2*FB))
                   - (((2*FB+5)'(15) * t3[k]) << FB)) >> FB);
      end
    end
  end

  logic [8:0] a3_d, b3_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      a3_d <= a3;
      b3_d <= b3;
    end
  end

  // s5: gradient codes and fade value
  logic [3:0]   h5 [8];
  logic [FB:0]  f5 [3];
  logic [FB-1:0] t5 [3];
  logic         m5;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!m4) begin
        // 2d corner hashes: perm(perm(x)+y) sits in the a/b level
        h5[0] <= 4'(pm(a3_d[7:0]));
        h5[1] <= 4'(pm(b3_d[7:0]));
        h5[2] <= 4'(pm(a3_d[7:0] + 8'd1));
        h5[3] <= 4'(pm(b3_d[7:0] + 8'd1));
      end else begin
        h5[0] <= 4'(pm(aa4[7:0]));
        h5[1] <= 4'(pm(ba4[7:0]));
        h5[2] <= 4'(pm(ab4[7:0]));
        h5[3] <= 4'(pm(bb4[7:0]));
      end
      h5[4] <= 4'(pm(aa4[7:0] + 8'd1));
      h5[5] <= 4'(pm(ba4[7:0] + 8'd1));
      h5[6] <= 4'(pm(ab4[7:0] + 8'd1));
      h5[7] <= 4'(pm(bb4[7:0] + 8'd1));
      m5 <= m4;
      for (int k = 0; k < 3; k++) begin
        logic [2*FB+1:0] fp;
        fp = tt4[k] * q4[k];
        f5[k] <= ((fp >> FB) > (2*FB+2)'(1 << FB)) ? (FB+1)'(1 << FB) : (FB+1)'(fp >> FB);
        t5[k] <= t4[k];
      end
    end
  end

  // s6: gradient dot products per corner
  function automatic logic signed [VW-1:0] grad(input logic [3:0] h, input logic m,
      input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
      input logic signed [VW-1:0] z);
    logic signed [VW-1:0] r;
    r = '0;
    if (!m) begin
      unique case (h[1:0])
        2'd0: r = x + y;
        2'd1: r = y - x;
        2'd2: r = x - y;
        default: r = -x - y;
      endcase
    end else begin
      unique case (h)
        4'd0, 4'd12: r = x + y;
        4'd1, 4'd14: r = y - x;
        4'd2: r = x - y;
        4'd3: r = -x - y;
        4'd4: r = x + z;
        4'd5: r = z - x;
        4'd6: r = x - z;
        4'd7: r = -x - z;
        4'd8: r = y + z;
        4'd9, 4'd13: r = z - y;
        4'd10: r = y - z;
        default: r = -y - z;
      endcase
    end
    return r;
  endfunction

  logic signed [VW-1:0] d6 [8];
  logic [FB:0]          f6 [3];
  logic                 m6;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [VW-1:0] x0, x1, y0, y1, z0, z1;
      x0 = VW'(t5[0]); x1 = x0 - VW'(1 << FB);
      y0 = VW'(t5[1]); y1 = y0 - VW'(1 << FB);
      z0 = VW'(t5[2]); z1 = z0 - VW'(1 << FB);
      d6[0] <= grad(h5[0], m5, x0, y0, z0);
      d6[1] <= grad(h5[1], m5, x1, y0, z0);
      d6[2] <= grad(h5[2], m5, x0, y1, z0);
      d6[3] <= grad(h5[3], m5, x1, y1, z0);
      d6[4] <= grad(h5[4], m5, x0, y0, z1);
      d6[5] <= grad(h5[5], m5, x1, y0, z1);
      d6[6] <= grad(h5[6], m5, x0, y1, z1);
      d6[7] <= grad(h5[7], m5, x1, y1, z1);
      f6 <= f5;
      m6 <= m5;
    end
  end

  // s7..s9: lerp tree along x, y, z
  logic signed [VW-1:0] l7 [4];
  logic signed [VW-1:0] l8 [2];
  logic signed [VW-1:0] l9;
  logic signed [VW-1:0] l9xy;
  logic [FB:0] fy7, fz7, fz8;
  logic        m7, m8, m9;
  for (genvar g = 0; g < 4; g++) begin : g_lx
    gn23_lerp #(.FRAC_BITS(FB), .VW(VW)) u_lx (
      .clk(clk), .en(adv), .f(f6[0]), .a(d6[2*g]), .b(d6[2*g+1]), .y(l7[g]));
  end
  for (genvar g = 0; g < 2; g++) begin : g_ly
    gn23_lerp #(.FRAC_BITS(FB), .VW(VW)) u_ly (
      .clk(clk), .en(adv), .f(fy7), .a(l7[2*g]), .b(l7[2*g+1]), .y(l8[g]));
  end
  gn23_lerp #(.FRAC_BITS(FB), .VW(VW)) u_lz (
    .clk(clk), .en(adv), .f(fz8), .a(l8[0]), .b(l8[1]), .y(l9));
  always_ff @(posedge clk) begin
    if (adv) begin
      fy7 <= f6[1]; fz7 <= f6[2]; fz8 <= fz7;
      m7 <= m6; m8 <= m7; m9 <= m8;
      // 2d result rides alongside the z level
      l9xy <= l8[0];
    end
  end

  // s10: 2d takes the y level, scale to q.16 and saturate
  logic signed [VW+16:0] r10;
  assign r10 = (FB > 16) ? (VW+17)'((m9 ? l9 : l9xy) >>> (FB - 16))
                         : (VW+17)'(m9 ? l9 : l9xy) <<< (16 - FB);
  always_ff @(posedge clk) begin
    if (adv) begin
      if (r10 > (VW+17)'(131071)) noise_value <= 18'sd131071;
      else if (r10 < -(VW+17)'(131072)) noise_value <= -18'sd131072;
      else noise_value <= OutW'(r10);
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid);
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> out_valid)
    else $error("input stalled with empty output");
  assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> $stable(noise_value)) else $error("held result changed");
endmodule
`default_nettype wire

/* test/gradient_noise_2d_3d_checker.sv */
// checker: watches both channels, predicts noise samples and compares them
`timescale 1ns / 1ps
module gradient_noise_2d_3d_checker import gn23_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [AddrW-1:0]         paddr,
  input  wire logic [31:0]              pwdata,
  input  wire logic                     pready,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire logic signed [CoordW-1:0] coord_x,
  input  wire logic signed [CoordW-1:0] coord_y,
  input  wire logic signed [CoordW-1:0] coord_z,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire logic signed [OutW-1:0]   noise_value,
  output int                            fail_count,
  output int                            pending
);
  localparam longint One = 64'sd65536;

  logic            mode_3d;
  logic [FreqW-1:0] freq_scale;
  logic signed [OutW-1:0] noise_q[$];

  function automatic longint floor_div(longint v);
    return v >>> 16;
  endfunction

  function automatic int unsigned perm(int unsigned i);
    logic [7:0] idx;
    idx = i[7:0];
    return PermRom[idx];
  endfunction

  function automatic void split_axis(logic signed [31:0] c, output int unsigned lat,
                                     output longint frac);
    longint p;
    p = longint'(c) * longint'({40'd0, freq_scale});
    lat = int'((p >>> 32) & 64'd255);
    frac = (p >>> 16) & 64'hffff;
  endfunction

  function automatic longint fade(longint t);
    longint t2, t3, q, f;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    q = (6 * t * t + 10 * One * One - 15 * t * One) >> 16;
    f = (t3 * q) >> 16;
    if (f > One) f = One;
    return f;
  endfunction

  function automatic longint blend(longint f, longint a, longint b);
    return a + floor_div(f * (b - a));
  endfunction

  function automatic longint dot2(int unsigned h, longint x, longint y);
    case (h & 3)
      0: return x + y;
      1: return -x + y;
      2: return x - y;
      default: return -x - y;
    endcase
  endfunction

  function automatic longint dot3(int unsigned h, longint x, longint y, longint z);
    case (h & 15)
      0, 12: return x + y;
      1, 14: return -x + y;
      2: return x - y;
      3: return -x - y;
      4: return x + z;
      5: return -x + z;
      6: return x - z;
      7: return -x - z;
      8: return y + z;
      9, 13: return -y + z;
      10: return y - z;
      default: return -y - z;
    endcase
  endfunction

  function automatic logic signed [OutW-1:0] noise_sample(logic signed [31:0] cx,
      logic signed [31:0] cy, logic signed [31:0] cz);
    int unsigned xi, yi, zi, a, aa, ab, b, ba, bb;
    longint xf, yf, zf, fx, fy, fz, r, x00, x10, x01, x11;
    split_axis(cx, xi, xf);
    split_axis(cy, yi, yf);
    fx = fade(xf);
    fy = fade(yf);
    if (!mode_3d) begin
      r = blend(fy,
        blend(fx, dot2(perm(perm(xi) + yi), xf, yf),
                  dot2(perm(perm(xi + 1) + yi), xf - One, yf)),
        blend(fx, dot2(perm(perm(xi) + yi + 1), xf, yf - One),
                  dot2(perm(perm(xi + 1) + yi + 1), xf - One, yf - One)));
    end else begin
      split_axis(cz, zi, zf);
      fz = fade(zf);
      a = perm(xi) + yi;
      aa = perm(a) + zi;
      ab = perm(a + 1) + zi;
      b = perm(xi + 1) + yi;
      ba = perm(b) + zi;
      bb = perm(b + 1) + zi;
      x00 = blend(fx, dot3(perm(aa), xf, yf, zf), dot3(perm(ba), xf - One, yf, zf));
      x10 = blend(fx, dot3(perm(ab), xf, yf - One, zf),
                      dot3(perm(bb), xf - One, yf - One, zf));
      x01 = blend(fx, dot3(perm(aa + 1), xf, yf, zf - One),
                      dot3(perm(ba + 1), xf - One, yf, zf - One));
      x11 = blend(fx, dot3(perm(ab + 1), xf, yf - One, zf - One),
                      dot3(perm(bb + 1), xf - One, yf - One, zf - One));
      r = blend(fz, blend(fy, x00, x10), blend(fy, x01, x11));
    end
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[OutW-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending = noise_q.size();

  always @(posedge clk) begin
    if (rst) begin
      mode_3d <= 1'b1;
      freq_scale <= FreqReset;
      fail_count = 0;
      noise_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == RegMode) mode_3d <= pwdata[0];
        else if (paddr == RegFreq) freq_scale <= pwdata[FreqW-1:0];
      end
      if (in_valid && in_ready) noise_q.push_back(noise_sample(coord_x, coord_y, coord_z));
      if (out_valid && out_ready) begin
        if (noise_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction %0d", noise_value));
        end else begin
          if (noise_value !== noise_q[0])
            report_mismatch($sformatf("noise_value %0d, want %0d", noise_value, noise_q[0]));
          void'(noise_q.pop_front());
        end
      end
    end
  end
endmodule

/* test/gradient_noise_2d_3d_core_tb.sv */
// testbench top: clock, reset, apb setup, coordinate stimulus and verdict
`timescale 1ns / 1ps
module gradient_noise_2d_3d_core_tb import gn23_pkg::*;;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [CoordW-1:0] coord_x, coord_y, coord_z;
  logic signed [OutW-1:0] noise_value;
  int fail_count, pending;
  int sender_idle, receiver_idle;
  longint cycle_count = 0;

  gradient_noise_2d_3d_core u_dut (.*);
  gradient_noise_2d_3d_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("gradient_noise_2d_3d_core_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= receiver_idle);
  end

  task automatic reg_write(logic [AddrW-1:0] addr, logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; coord_x <= x; coord_y <= y; coord_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      2: return {16'($urandom_range(3) * 16'h4000), 16'($urandom)};
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  logic [31:0] edge_vals[8] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                32'h0001_0000, 32'h0000_8000, 32'h0000_ffff, 32'hffff_0001};
  logic [31:0] freq_set[6] = '{32'h0, 32'h00ff_ffff, 32'h0001_0000, 32'hff00_8000,
                               32'h0000_0001, 32'h0004_0000};

  initial begin
    rst <= 1'b1;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
    in_valid <= 0; coord_x <= '0; coord_y <= '0; coord_z <= '0;
    sender_idle = 25; receiver_idle = 55;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: corners of the coordinate range at reset settings, then both modes
    for (int i = 0; i < 8; i++) send_point(edge_vals[i], edge_vals[7-i], edge_vals[(i+3)%8]);
    drain();
    reg_write(RegMode, 32'hffff_fffe);
    reg_write(RegFreq, 32'h0002_8000);
    for (int i = 0; i < 8; i++) send_point(edge_vals[i], edge_vals[(i+5)%8], $urandom);
    drain();
    reg_write(RegFreq, 32'h0);
    send_point(32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff);
    drain();
    // random phases over modes and frequencies
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin sender_idle = 55; receiver_idle = 25; end
      if (ph == 8) begin sender_idle = 0; receiver_idle = 0; end
      reg_write(RegMode, {31'($urandom), 1'(ph)});
      reg_write(RegFreq, (ph % 6 == 5) ? $urandom : freq_set[ph % 6]);
      for (int n = 0; n < 150; n++) send_point(pick_coord(), pick_coord(), pick_coord());
      drain();
    end
    if (fail_count == 0) begin
      $display("gradient_noise_2d_3d_core_tb passed");
    end else begin
      $display("gradient_noise_2d_3d_core_tb failed");
    end
    $finish;
  end
endmodule
